// ===== rtl/wmh_pkg.sv =====
// Shared types and constants of the weighted Manhattan heuristic engine.
package wmh_pkg;

  localparam int MAX_CELLS_DEF  = 64;
  localparam int COST_WIDTH_DEF = 16;

  localparam int OP_W    = 1;
  localparam int POS_W   = 6;
  localparam int TILE_W  = 6;
  localparam int MCOST_W = 16;
  localparam int COLS_W  = 4;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 3;
  localparam int DIST_W  = 7;
  localparam int SUM_W   = 26;

  localparam logic [COLS_W-1:0] COLS_RESET = 4'd4;
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_EVAL = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // One classified word as it travels from front to back.
  typedef struct packed {
    logic              is_load;
    logic              adds;
    logic              last;
    logic [TILE_W-1:0] tile;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/wmh_queue.sv =====
// Two-entry queue between the front and back parts.
module wmh_queue #(
  parameter int W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [W-1:0]          push_data,
  input  logic                  pop,
  output logic [W-1:0]          pop_data,
  output wmh_pkg::q_status_t    status
);

  localparam int DEPTH = wmh_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/wmh_front.sv =====
// Front part: column register, input handshake, row/column split and classification.
module wmh_front #(
  parameter int MAX_CELLS  = wmh_pkg::MAX_CELLS_DEF,
  parameter int COST_WIDTH = wmh_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [wmh_pkg::COLS_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wmh_pkg::OP_W-1:0]      in_operation,
  input  logic [wmh_pkg::POS_W-1:0]     in_position,
  input  logic [wmh_pkg::TILE_W-1:0]    in_tile,
  input  logic [wmh_pkg::MCOST_W-1:0]   in_move_cost,
  input  logic                          in_last_cell,
  input  wmh_pkg::q_status_t            q_status,
  output logic                          push,
  output wmh_pkg::entry_t               push_entry,
  output logic [COST_WIDTH-1:0]         push_cost
);

  localparam int RECIP_SHIFT = 10;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QPROD_W     = wmh_pkg::POS_W + RECIP_W;
  localparam int QC_W        = wmh_pkg::POS_W + wmh_pkg::COLS_W;

  logic [wmh_pkg::COLS_W-1:0] cols_r;
  logic [wmh_pkg::COLS_W-1:0] cols_eff;
  logic [RECIP_W-1:0]         recip;
  logic [QPROD_W-1:0]         q_prod;
  logic [wmh_pkg::ROW_W-1:0]  row;
  logic [QC_W-1:0]            qc;
  logic [QC_W-1:0]            col_full;
  logic                       accept;
  logic                       in_range;
  logic                       is_load;
  logic [31:0]                cost_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= wmh_pkg::COLS_RESET;
    end else if (cfg_write_en) begin
      cols_r <= cfg_write_data;
    end
  end

  // Zero counts as one column, anything above eight as eight.
  always_comb begin
    if (cols_r == '0) begin
      cols_eff = 4'd1;
    end else if (cols_r > 4'd8) begin
      cols_eff = 4'd8;
    end else begin
      cols_eff = cols_r;
    end
  end

  // ceil(1024 / cols): exact quotient for every 6-bit position.
  always_comb begin
    unique case (cols_eff)
      4'd2:    recip = 11'd512;
      4'd3:    recip = 11'd342;
      4'd4:    recip = 11'd256;
      4'd5:    recip = 11'd205;
      4'd6:    recip = 11'd171;
      4'd7:    recip = 11'd147;
      4'd8:    recip = 11'd128;
      default: recip = 11'd1024;
    endcase
  end

  assign q_prod   = QPROD_W'(in_position) * QPROD_W'(recip);
  assign row      = q_prod[RECIP_SHIFT +: wmh_pkg::ROW_W];
  assign qc       = QC_W'(row) * QC_W'(cols_eff);
  assign col_full = QC_W'(in_position) - qc;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign in_range = ({3'b000, in_tile} < 9'(MAX_CELLS));
  assign is_load  = (in_operation == wmh_pkg::OP_LOAD);

  // Drop loads of tiles beyond the table; they leave no trace.
  assign push = accept && (!is_load || in_range);

  assign push_entry.is_load = is_load;
  assign push_entry.adds    = !is_load && in_range && (in_tile != '0);
  assign push_entry.last    = !is_load && in_last_cell;
  assign push_entry.tile    = in_tile;
  assign push_entry.row     = row;
  assign push_entry.col     = col_full[wmh_pkg::COL_W-1:0];

  assign cost_ext  = {16'h0000, in_move_cost};
  assign push_cost = cost_ext[COST_WIDTH-1:0];

endmodule

// ===== rtl/wmh_back.sv =====
// Back part: goal table, distance times cost, saturating accumulator and result register.
module wmh_back #(
  parameter int MAX_CELLS  = wmh_pkg::MAX_CELLS_DEF,
  parameter int COST_WIDTH = wmh_pkg::COST_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wmh_pkg::q_status_t          q_status,
  input  wmh_pkg::entry_t             q_entry,
  input  logic [COST_WIDTH-1:0]       q_cost,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wmh_pkg::SUM_W-1:0]   out_heuristic_value
);

  localparam int IDX_W  = $clog2(MAX_CELLS);
  localparam int ROW_W  = wmh_pkg::ROW_W;
  localparam int COL_W  = wmh_pkg::COL_W;
  localparam int DIST_W = wmh_pkg::DIST_W;
  localparam int SUM_W  = wmh_pkg::SUM_W;
  localparam int MEM_W  = ROW_W + COL_W + COST_WIDTH;
  localparam int PROD_W = DIST_W + COST_WIDTH;
  localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

  logic [MEM_W-1:0]  goal_mem [MAX_CELLS];
  logic [MEM_W-1:0]  rd_data_r;
  logic [7:0]        tile_ext;
  logic [IDX_W-1:0]  idx;
  logic              adv;

  logic              s2_valid_r, s2_valid_nxt;
  logic              s2_adds_r;
  logic              s2_last_r;
  logic [ROW_W-1:0]  s2_row_r;
  logic [COL_W-1:0]  s2_col_r;

  logic              s3_valid_r, s3_valid_nxt;
  logic              s3_last_r;
  logic [PROD_W-1:0] s3_prod_r;

  logic [ROW_W-1:0]      g_row;
  logic [COL_W-1:0]      g_col;
  logic [COST_WIDTH-1:0] g_cost;
  logic [ROW_W-1:0]      d_row;
  logic [COL_W-1:0]      d_col;
  logic [DIST_W-1:0]     step_dist;
  logic [PROD_W-1:0]     prod;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [ACC_W-1:0]  sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_data_r;
  logic              emit;

  // Freeze the whole back part while a finished sum waits on a full result register.
  assign adv = !(s3_valid_r && s3_last_r && out_valid_r && !out_ready);
  assign pop = adv && !q_status.empty;

  assign tile_ext = {2'b00, q_entry.tile};
  assign idx      = tile_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (pop && q_entry.is_load) begin
      goal_mem[idx] <= {q_entry.row, q_entry.col, q_cost};
    end
    if (pop && !q_entry.is_load) begin
      rd_data_r <= goal_mem[idx];
    end
  end

  // Stage two: carry the current cell alongside the table read.
  assign s2_valid_nxt = adv ? (pop && !q_entry.is_load) : s2_valid_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_adds_r <= q_entry.adds;
      s2_last_r <= q_entry.last;
      s2_row_r  <= q_entry.row;
      s2_col_r  <= q_entry.col;
    end
  end

  assign g_row     = rd_data_r[MEM_W-1 -: ROW_W];
  assign g_col     = rd_data_r[COST_WIDTH +: COL_W];
  assign g_cost    = rd_data_r[COST_WIDTH-1:0];
  assign d_row     = (s2_row_r >= g_row) ? s2_row_r - g_row : g_row - s2_row_r;
  assign d_col     = (s2_col_r >= g_col) ? s2_col_r - g_col : g_col - s2_col_r;
  assign step_dist = DIST_W'(d_row) + DIST_W'(d_col);
  assign prod      = s2_adds_r ? PROD_W'(step_dist) * PROD_W'(g_cost) : '0;

  // Stage three: weighted distance registered ahead of the accumulator.
  assign s3_valid_nxt = adv ? s2_valid_r : s3_valid_r;

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      s3_last_r <= s2_last_r;
      s3_prod_r <= prod;
    end
  end

  assign sum_ext = ACC_W'(sum_r) + ACC_W'(s3_prod_r);
  assign sum_sat = (sum_ext > ACC_W'(wmh_pkg::SUM_MAX)) ? wmh_pkg::SUM_MAX
                                                      : sum_ext[SUM_W-1:0];
  assign emit    = adv && s3_valid_r && s3_last_r;

  always_comb begin
    sum_nxt = sum_r;
    if (adv && s3_valid_r) begin
      sum_nxt = s3_last_r ? '0 : sum_sat;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= sum_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_heuristic_value = out_data_r;

endmodule

// ===== rtl/weighted_manhattan_heuristic.sv =====
// Top level of the weighted Manhattan heuristic engine.
//
// Takes one word per cycle on the input channel, loads and board cells alike, as long as
// the result side keeps up; the single port of the goal table (one write or one read per
// cycle) sets that rate. The last cell of a state passes through the queue, the goal table
// read register and the stage-three register after the multiply, then its sum goes into the
// result register. A result left waiting holds the back part once the next finished sum
// reaches the accumulator; the two-entry queue then lets the input side take up to two
// more words before it stalls. cfg_write_data sets the column count used to split
// positions; write it only while the block is idle.
module weighted_manhattan_heuristic #(
  parameter int MAX_CELLS  = wmh_pkg::MAX_CELLS_DEF,
  parameter int COST_WIDTH = wmh_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [wmh_pkg::COLS_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wmh_pkg::OP_W-1:0]      in_operation,
  input  logic [wmh_pkg::POS_W-1:0]     in_position,
  input  logic [wmh_pkg::TILE_W-1:0]    in_tile,
  input  logic [wmh_pkg::MCOST_W-1:0]   in_move_cost,
  input  logic                          in_last_cell,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wmh_pkg::SUM_W-1:0]     out_heuristic_value
);

  localparam int QW = $bits(wmh_pkg::entry_t) + COST_WIDTH;

  wmh_pkg::q_status_t    q_status;
  wmh_pkg::entry_t       push_entry;
  wmh_pkg::entry_t       pop_entry;
  logic [COST_WIDTH-1:0] push_cost;
  logic [COST_WIDTH-1:0] pop_cost;
  logic [QW-1:0]         pop_data;
  logic                  push;
  logic                  pop;

  wmh_front #(
    .MAX_CELLS  (MAX_CELLS),
    .COST_WIDTH (COST_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_tile        (in_tile),
    .in_move_cost   (in_move_cost),
    .in_last_cell   (in_last_cell),
    .q_status       (q_status),
    .push           (push),
    .push_entry     (push_entry),
    .push_cost      (push_cost)
  );

  wmh_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_entry, push_cost}),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  assign pop_entry = wmh_pkg::entry_t'(pop_data[QW-1:COST_WIDTH]);
  assign pop_cost  = pop_data[COST_WIDTH-1:0];

  wmh_back #(
    .MAX_CELLS  (MAX_CELLS),
    .COST_WIDTH (COST_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_status            (q_status),
    .q_entry             (pop_entry),
    .q_cost              (pop_cost),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_heuristic_value (out_heuristic_value)
  );

endmodule

// ===== rtl/wmh_checker.sv =====
// Port-level checks of the heuristic engine, bound to the top level.
module wmh_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wmh_pkg::SUM_W-1:0]   out_heuristic_value
);

  // Reset empties the queue and the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("reset left a result pending or the input stalled");

  // The input side only stalls once a word has gone into the queue.
  a_ready_falls_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready && rst_n))
    else $error("in_ready fell without an accepted word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_heuristic_value))
    else $error("result changed while stalled");

endmodule

bind weighted_manhattan_heuristic wmh_checker u_wmh_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_heuristic_value (out_heuristic_value)
);
